// File: design/sat_pkg.sv
// ----------------------------------------------------------------------------
// sat_pkg
// Shared types, constants and helpers for the strongest AP tracker.
// ----------------------------------------------------------------------------
package sat_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  // entry status codes
  localparam logic [1:0] ST_IGNORED  = 2'd0;
  localparam logic [1:0] ST_UPDATED  = 2'd1;
  localparam logic [1:0] ST_INSERTED = 2'd2;
  localparam logic [1:0] ST_DROPPED  = 2'd3;

  typedef struct packed {
    logic              sender_is_ap;
    logic [15:0]       node_number;
    logic signed [7:0] rx_signal;
  } frame_t;

  typedef struct packed {
    logic [1:0]  entry_status;
    logic        best_valid;
    logic [15:0] best_node;
    logic [4:0]  entry_count;
  } report_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic scan_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic out_free;
  } sts_t;

  // |dBm|; -128 maps to 128, which still fits in 8 unsigned bits
  function automatic logic [7:0] magnitude(input logic signed [7:0] s);
    logic [7:0] r;
    r = s[7] ? (8'd0 - 8'(s)) : 8'(s);
    return r;
  endfunction

endpackage

// File: design/strongest_ap_tracker.sv
// ----------------------------------------------------------------------------
// strongest_ap_tracker
// Keeps a table of access points and reports the one heard most strongly.
// ----------------------------------------------------------------------------
// Each frame request carries the sender's AP flag, node number and signal in
// whole dBm. Non-AP frames leave the table alone. A known AP has its signal
// refreshed, a new one is appended, or dropped (status 3) once all
// TABLE_DEPTH entries are in use. Every request yields one report request:
// status, the AP with the smallest |dBm| (later entry wins a tie, node 0 and
// best_valid low when the table is empty) and the number of stored APs.
// Sequence: after acceptance the table memory is read one entry per cycle,
// once for each of the N stored entries; the last read word is compared in
// a drain step, and a final step commits the table write and loads the
// report. An empty table goes from acceptance straight to the final step.
// The next request is taken once the sequencer is back in idle.
// Requests are processed one at a time; a new request can be accepted while
// the previous report is still stalled, and it then waits in its final step
// until the report register frees up. No clearing pass is needed after
// reset: only entries below the stored count are ever read.
// ----------------------------------------------------------------------------
module strongest_ap_tracker (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  output logic             frame_stall,
  input  sat_pkg::frame_t  frame,
  output logic             report_valid,
  input  logic             report_stall,
  output sat_pkg::report_t report
);
  import sat_pkg::*;

  cmd_t cmd;
  sts_t sts;

  sat_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (frame_valid),
    .frame_stall (frame_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  sat_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .frame        (frame),
    .cmd          (cmd),
    .sts          (sts),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report)
  );

  // a fresh report only follows a request that was in progress
  a_report_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(report_valid) |-> $past(frame_stall))
    else $error("report raised without a request in progress");

  // empty table reports node 0
  a_empty_node_zero: assert property (@(posedge clk) disable iff (rst)
    (report_valid && !report.best_valid) |-> (report.best_node == 16'd0))
    else $error("best_node non-zero with empty table");

  // an insert always leaves a valid best entry
  a_insert_valid: assert property (@(posedge clk) disable iff (rst)
    (report_valid && (report.entry_status == ST_INSERTED)) |-> report.best_valid)
    else $error("insert reported without a best entry");

  // the frame port closes once a request has been taken
  a_take_when_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.start) |=> frame_stall)
    else $error("frame port open while a request is in progress");

endmodule

// File: design/sat_ctrl.sv
// ----------------------------------------------------------------------------
// sat_ctrl
// Sequencer: accept a request, walk the table, then commit and report.
// ----------------------------------------------------------------------------
module sat_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          frame_valid,
  output logic          frame_stall,
  input  sat_pkg::sts_t sts,
  output sat_pkg::cmd_t cmd
);
  import sat_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    cmd           = '0;
    frame_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        frame_stall = 1'b0;
        if (frame_valid) begin
          cmd.start  = 1'b1;
          state_next = sts.count_zero ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read word is compared this cycle
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/sat_datapath.sv
// ----------------------------------------------------------------------------
// sat_datapath
// AP table memory, match/minimum scan registers and the report register.
// ----------------------------------------------------------------------------
module sat_datapath (
  input  logic             clk,
  input  logic             rst,
  input  sat_pkg::frame_t  frame,
  input  sat_pkg::cmd_t    cmd,
  output sat_pkg::sts_t    sts,
  output logic             report_valid,
  input  logic             report_stall,
  output sat_pkg::report_t report
);
  import sat_pkg::*;

  logic [15:0]       node_mem [TABLE_DEPTH];
  logic signed [7:0] sig_mem  [TABLE_DEPTH];

  logic [CNT_W-1:0]  count;
  frame_t            cur;
  logic [IDX_W-1:0]  idx;

  logic              rd_vld;
  logic [IDX_W-1:0]  rd_idx;
  logic [15:0]       rd_node;
  logic signed [7:0] rd_sig;

  logic              best_found;
  logic [7:0]        best_mag;
  logic [15:0]       best_node;
  logic              match_found;
  logic [IDX_W-1:0]  match_idx;

  // scan compare
  logic              hit;
  logic signed [7:0] eff_sig;
  logic [7:0]        eff_mag;

  // commit
  logic              full;
  logic              do_update;
  logic              do_insert;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [7:0]        new_mag;
  logic              take_new;
  logic [CNT_W-1:0]  count_next;
  logic [CNT_W+4:0]  count_ext;
  logic [1:0]        status;

  assign hit     = cur.sender_is_ap && (rd_node == cur.node_number);
  assign eff_sig = hit ? cur.rx_signal : rd_sig;
  assign eff_mag = magnitude(eff_sig);

  assign full      = (count == CNT_W'(TABLE_DEPTH));
  assign do_update = cur.sender_is_ap && match_found;
  assign do_insert = cur.sender_is_ap && !match_found && !full;
  assign wr_en     = cmd.finish && (do_update || do_insert);
  assign wr_addr   = do_update ? match_idx : count[IDX_W-1:0];
  assign new_mag   = magnitude(cur.rx_signal);
  // appended entry has the top index, so it wins ties
  assign take_new  = do_insert && (!best_found || (best_mag >= new_mag));
  assign count_next = do_insert ? (count + CNT_W'(1)) : count;
  assign count_ext  = {5'd0, count_next};

  always_comb begin
    if (!cur.sender_is_ap) begin
      status = ST_IGNORED;
    end else if (match_found) begin
      status = ST_UPDATED;
    end else if (!full) begin
      status = ST_INSERTED;
    end else begin
      status = ST_DROPPED;
    end
  end

  assign sts.count_zero = (count == '0);
  assign sts.scan_last  = ((CNT_W'(idx) + CNT_W'(1)) == count);
  assign sts.out_free   = !report_valid || !report_stall;

  // table memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      node_mem[wr_addr] <= cur.node_number;
      sig_mem[wr_addr]  <= cur.rx_signal;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      rd_node <= node_mem[idx];
      rd_sig  <= sig_mem[idx];
      rd_idx  <= idx;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      rd_vld       <= 1'b0;
      report_valid <= 1'b0;
    end else begin
      rd_vld <= cmd.scan_step;
      if (cmd.finish) begin
        count <= count_next;
      end
      if (cmd.finish) begin
        report_valid <= 1'b1;
      end else if (!report_stall) begin
        report_valid <= 1'b0;
      end
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur         <= frame;
      idx         <= '0;
      best_found  <= 1'b0;
      match_found <= 1'b0;
    end else begin
      if (cmd.scan_step) begin
        idx <= idx + IDX_W'(1);
      end
      if (rd_vld) begin
        if (hit) begin
          match_found <= 1'b1;
          match_idx   <= rd_idx;
        end
        if (!best_found || (best_mag >= eff_mag)) begin
          best_found <= 1'b1;
          best_mag   <= eff_mag;
          best_node  <= rd_node;
        end
      end
    end
  end

  // report register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      report.entry_status <= status;
      report.best_valid   <= best_found || do_insert;
      if (take_new) begin
        report.best_node <= cur.node_number;
      end else if (best_found) begin
        report.best_node <= best_node;
      end else begin
        report.best_node <= 16'd0;
      end
      report.entry_count <= count_ext[4:0];
    end
  end

endmodule
